[sv/cfba_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfba_pkg: shared types and constants
// Widths, status codes, register indexes and controller states of the
// chunked fixed-block allocator.
// ---------------------------------------------------------------------------
package cfba_pkg;
   localparam int MaxChunks  = 16;
   localparam int MaxBlocks  = 255;
   localparam int SlotW      = 4;
   localparam int BlockW     = 8;
   localparam int LinkAddrW  = SlotW + BlockW;
   localparam int LinkDepth  = 1 << LinkAddrW;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

   localparam logic REG_BLOCK_SIZE = 1'b0;
   localparam logic REG_BLOCKS_PER_CHUNK = 1'b1;

   localparam logic [4:0] NO_CACHE = 5'd31;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ACACHE, ST_ASCAN, ST_AINIT, ST_AGRANT, ST_AREAD,
      ST_FSCAN, ST_FPUSH, ST_FEMPTY, ST_DONE
   } state_type;
endpackage

[sv/cfba_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfba channel interfaces
// Request, response and register-write channels with valid/ready.
// ---------------------------------------------------------------------------
interface cfba_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [3:0] chunk_slot;
   logic [7:0] block_index;
   modport source (output valid, mode, chunk_slot, block_index, input ready);
   modport sink (input valid, mode, chunk_slot, block_index, output ready);
endinterface

interface cfba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  granted_chunk;
   logic [7:0]  granted_block;
   logic [15:0] byte_offset;
   modport source (output valid, status, granted_chunk, granted_block, byte_offset,
                   input ready);
   modport sink (input valid, status, granted_chunk, granted_block, byte_offset,
                 output ready);
endinterface

interface cfba_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [8:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[sv/cfba_link_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfba_link_ram: next-block link store
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module cfba_link_ram
   import cfba_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [LinkAddrW-1:0] wr_addr,
   input  logic [BlockW-1:0]    wr_data,
   input  logic [LinkAddrW-1:0] rd_addr,
   output logic [BlockW-1:0]    rd_data
);
   logic [BlockW-1:0] mem [LinkDepth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[sv/chunked_fixed_block_allocator_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chunked_fixed_block_allocator_unit: fixed-size block pool over 16 chunks
// Allocates and frees blocks, one request word at a time.
// ---------------------------------------------------------------------------
// One request word is taken at a time and answered by one response word.
// An allocate that hits the cached chunk goes straight to the grant and
// link read; one that misses scans the chunk list one entry a cycle, and one
// that opens a fresh chunk also writes its free-list links one a cycle, since
// those links live in a 4096x8 link RAM with a single write port. A free scans
// the chunk list one entry a cycle and pushes the block; an emptied chunk
// moves last, or an empty last chunk is released. The result sits in an output
// register, so a waiting response does not stall the controller until the
// next result is ready. Write block_size (index 0) and blocks_per_chunk
// (index 1) only while idle; a blocks_per_chunk of zero acts as one.
module chunked_fixed_block_allocator_unit
   import cfba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   cfba_req_if.sink     req_ch,
   cfba_rsp_if.source   rsp_ch,
   cfba_csr_if.sink     csr_ch
);
   state_type state_ff, state_in;

   logic [8:0] bsize_ff, bsize_in;
   logic [7:0] bpc_ff, bpc_in;
   logic [7:0] bpc;

   logic [7:0] head_ff [MaxChunks];
   logic [7:0] head_in [MaxChunks];
   logic [7:0] cnt_ff  [MaxChunks];
   logic [7:0] cnt_in  [MaxChunks];
   logic [3:0] order_ff [MaxChunks];
   logic [3:0] order_in [MaxChunks];
   logic [15:0] mask_ff, mask_in;
   logic [4:0] n_ff, n_in;
   logic [4:0] acache_ff, acache_in;
   logic [4:0] pos_ff, pos_in;
   logic [7:0] idx_ff, idx_in;
   logic [3:0] slot_ff, slot_in;
   logic [7:0] blk_ff, blk_in;

   logic [1:0]  res_status_ff, res_status_in;
   logic [3:0]  res_chunk_ff, res_chunk_in;
   logic [7:0]  res_block_ff, res_block_in;
   logic [15:0] res_offset_ff, res_offset_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [3:0]  rsp_chunk_ff;
   logic [7:0]  rsp_block_ff;
   logic [15:0] rsp_offset_ff;

   logic                 ram_we;
   logic [LinkAddrW-1:0] ram_waddr, ram_raddr;
   logic [BlockW-1:0]    ram_wdata, ram_rdata;

   // shared decisions
   logic       req_take, rsp_load;
   logic       cache_hit, scan_in_range, scan_hit, room, fscan_hit, free_bad;
   logic       free_full, mem_any_free;
   logic [3:0] first_free;
   logic [4:0] n_m1, n_m2;
   logic [3:0] last_slot;
   logic [7:0] cnt_plus;

   cfba_link_ram u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign bpc = (bpc_ff == 8'd0) ? 8'd1 : bpc_ff;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_take = req_ch.valid && req_ch.ready;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.granted_chunk = rsp_chunk_ff;
   assign rsp_ch.granted_block = rsp_block_ff;
   assign rsp_ch.byte_offset = rsp_offset_ff;

   assign n_m1 = n_ff - 5'd1;
   assign n_m2 = n_ff - 5'd2;
   assign last_slot = order_ff[n_m1[3:0]];
   assign cnt_plus = cnt_ff[slot_ff] + 8'd1;

   assign cache_hit = (acache_ff < n_ff) && (cnt_ff[order_ff[acache_ff[3:0]]] != 8'd0);
   assign scan_in_range = (idx_ff < {3'd0, n_ff});
   assign scan_hit = cnt_ff[order_ff[idx_ff[3:0]]] != 8'd0;
   assign fscan_hit = order_ff[idx_ff[3:0]] == slot_ff;
   assign free_bad = !mask_ff[slot_ff] || (blk_ff >= bpc) || (cnt_ff[slot_ff] >= bpc);
   assign free_full = cnt_plus == bpc;

   // lowest unused chunk slot
   always_comb begin
      first_free = '0;
      mem_any_free = 1'b0;
      for (int k = MaxChunks - 1; k >= 0; k--) begin
         if (!mask_ff[k]) begin
            first_free = k[3:0];
            mem_any_free = 1'b1;
         end
      end
   end
   assign room = (n_ff < 5'(MaxChunks)) && mem_any_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = req_ch.mode ? ST_FSCAN : ST_ACACHE;
         end
         ST_ACACHE: state_in = cache_hit ? ST_AGRANT : ST_ASCAN;
         ST_ASCAN: begin
            if (scan_in_range) begin
               if (scan_hit) state_in = ST_AGRANT;
            end else begin
               state_in = room ? ST_AINIT : ST_DONE;
            end
         end
         ST_AINIT: begin
            if (idx_ff == bpc - 8'd1) state_in = ST_AGRANT;
         end
         ST_AGRANT: state_in = ST_AREAD;
         ST_AREAD:  state_in = ST_DONE;
         ST_FSCAN: begin
            if (!scan_in_range) state_in = ST_DONE;
            else if (fscan_hit) state_in = ST_FPUSH;
         end
         ST_FPUSH: state_in = (free_bad || !free_full) ? ST_DONE : ST_FEMPTY;
         ST_FEMPTY: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      bsize_in = bsize_ff;
      bpc_in = bpc_ff;
      head_in = head_ff;
      cnt_in = cnt_ff;
      order_in = order_ff;
      mask_in = mask_ff;
      n_in = n_ff;
      acache_in = acache_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      slot_in = slot_ff;
      blk_in = blk_ff;
      res_status_in = res_status_ff;
      res_chunk_in = res_chunk_ff;
      res_block_in = res_block_ff;
      res_offset_in = res_offset_ff;
      ram_we = 1'b0;
      ram_waddr = {slot_ff, idx_ff};
      ram_wdata = idx_ff + 8'd1;
      ram_raddr = {order_ff[pos_ff[3:0]], head_ff[order_ff[pos_ff[3:0]]]};

      if (csr_ch.valid) begin
         if (csr_ch.index == REG_BLOCK_SIZE) bsize_in = csr_ch.data;
         else bpc_in = csr_ch.data[7:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               slot_in = req_ch.chunk_slot;
               blk_in = req_ch.block_index;
               idx_in = '0;
               res_status_in = STATUS_OK;
               res_chunk_in = '0;
               res_block_in = '0;
               res_offset_in = '0;
            end
         end
         ST_ACACHE: begin
            pos_in = acache_ff;
            idx_in = '0;
         end
         ST_ASCAN: begin
            if (scan_in_range) begin
               // take the first listed chunk with space
               if (scan_hit) pos_in = idx_ff[4:0];
               else idx_in = idx_ff + 8'd1;
            end else if (room) begin
               // open a fresh chunk at the end of the list
               mask_in[first_free] = 1'b1;
               head_in[first_free] = '0;
               cnt_in[first_free] = bpc;
               order_in[n_ff[3:0]] = first_free;
               pos_in = n_ff;
               n_in = n_ff + 5'd1;
               slot_in = first_free;
               idx_in = '0;
            end else begin
               res_status_in = STATUS_NO_ROOM;
            end
         end
         ST_AINIT: begin
            ram_we = 1'b1;
            idx_in = idx_ff + 8'd1;
         end
         ST_AGRANT: begin
            slot_in = order_ff[pos_ff[3:0]];
            blk_in = head_ff[order_ff[pos_ff[3:0]]];
            acache_in = pos_ff;
         end
         ST_AREAD: begin
            head_in[slot_ff] = ram_rdata;
            cnt_in[slot_ff] = cnt_ff[slot_ff] - 8'd1;
            res_chunk_in = slot_ff;
            res_block_in = blk_ff;
            res_offset_in = 16'({8'd0, blk_ff} * {7'd0, bsize_ff});
         end
         ST_FSCAN: begin
            if (!scan_in_range) res_status_in = STATUS_BAD_FREE;
            else if (fscan_hit) pos_in = idx_ff[4:0];
            else idx_in = idx_ff + 8'd1;
         end
         ST_FPUSH: begin
            if (free_bad) begin
               res_status_in = STATUS_BAD_FREE;
            end else begin
               // push the block onto its chunk's free list
               ram_we = 1'b1;
               ram_waddr = {slot_ff, blk_ff};
               ram_wdata = head_ff[slot_ff];
               head_in[slot_ff] = blk_ff;
               cnt_in[slot_ff] = cnt_plus;
            end
         end
         ST_FEMPTY: begin
            if (pos_ff == n_m1) begin
               if (n_ff > 5'd1 && cnt_ff[order_ff[n_m2[3:0]]] == bpc) begin
                  mask_in[last_slot] = 1'b0;
                  n_in = n_m1;
                  acache_in = '0;
               end
            end else if (cnt_ff[last_slot] == bpc) begin
               mask_in[last_slot] = 1'b0;
               n_in = n_m1;
               acache_in = pos_ff;
            end else begin
               // swap the emptied chunk to the end of the list
               order_in[pos_ff[3:0]] = last_slot;
               order_in[n_m1[3:0]] = slot_ff;
               acache_in = n_m1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bsize_ff <= 9'd1;
         bpc_ff <= 8'd255;
         mask_ff <= '0;
         n_ff <= '0;
         acache_ff <= NO_CACHE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MaxChunks; k++) begin
            head_ff[k] <= '0;
            cnt_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         bsize_ff <= bsize_in;
         bpc_ff <= bpc_in;
         mask_ff <= mask_in;
         n_ff <= n_in;
         acache_ff <= acache_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff <= head_in;
         cnt_ff <= cnt_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      order_ff <= order_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      slot_ff <= slot_in;
      blk_ff <= blk_in;
      res_status_ff <= res_status_in;
      res_chunk_ff <= res_chunk_in;
      res_block_ff <= res_block_in;
      res_offset_ff <= res_offset_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_chunk_ff <= res_chunk_ff;
         rsp_block_ff <= res_block_ff;
         rsp_offset_ff <= res_offset_ff;
      end
   end
endmodule

[bench/chunked_fixed_block_allocator_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chunked_fixed_block_allocator_unit_tb: self-checking bench for the allocator
// Drives allocate and free words against a behavioral pool model, across
// several block sizes and chunk sizes, with random gaps on both channels.
// Each response word is compared with the oldest predicted grant.
// ---------------------------------------------------------------------------
module chunked_fixed_block_allocator_unit_tb
   import cfba_pkg::*;
();

   localparam bit MODE_ALLOC = 1'b0;
   localparam bit MODE_FREE  = 1'b1;
   localparam int NO_POS     = 31;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  chunk;
      logic [7:0]  blk;
      logic [15:0] offset;
   } grant_type;

   typedef struct packed {
      bit         mode;
      bit [3:0]   slot;
      bit [7:0]   blk;
      bit         typed;
      grant_type  grant;
   } stim_row_type;

   typedef struct packed {
      bit [3:0] slot;
      bit [7:0] blk;
   } block_ref_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cfba_req_if req_ch ();
   cfba_rsp_if rsp_ch ();
   cfba_csr_if csr_ch ();

   chunked_fixed_block_allocator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pool model: embedded free lists, chunk order list and allocation cache.
   logic [7:0]  pool_link [LinkDepth];
   logic [7:0]  pool_head [MaxChunks];
   logic [7:0]  pool_count [MaxChunks];
   logic [15:0] pool_used;
   logic [3:0]  pool_order [MaxChunks];
   int          pool_listed;
   int          pool_alloc_pos;
   logic [8:0]  cfg_block_size;
   logic [7:0]  cfg_blocks;

   grant_type      pending_grants [$];
   block_ref_type  live_blocks [$];
   int             fail_count = 0;

   stim_row_type directed_rows [11] = '{
      '{MODE_FREE,  4'd0,  8'd0,   1'b1, '{STATUS_BAD_FREE, 4'd0, 8'd0, 16'd0}},
      '{MODE_ALLOC, 4'd0,  8'd0,   1'b1, '{STATUS_OK,       4'd0, 8'd0, 16'd0}},
      '{MODE_ALLOC, 4'd0,  8'd0,   1'b1, '{STATUS_OK,       4'd0, 8'd1, 16'd256}},
      '{MODE_FREE,  4'd0,  8'd255, 1'b1, '{STATUS_BAD_FREE, 4'd0, 8'd0, 16'd0}},
      '{MODE_FREE,  4'd15, 8'd254, 1'b1, '{STATUS_BAD_FREE, 4'd0, 8'd0, 16'd0}},
      '{MODE_FREE,  4'd0,  8'd1,   1'b1, '{STATUS_OK,       4'd0, 8'd0, 16'd0}},
      '{MODE_ALLOC, 4'd0,  8'd0,   1'b1, '{STATUS_OK,       4'd0, 8'd1, 16'd256}},
      '{MODE_FREE,  4'd0,  8'd0,   1'b0, '0},
      '{MODE_FREE,  4'd0,  8'd1,   1'b0, '0},
      '{MODE_ALLOC, 4'd0,  8'd0,   1'b0, '0},
      '{MODE_FREE,  4'd7,  8'd128, 1'b0, '0}
   };

   function automatic int blocks_now();
      return (cfg_blocks == 8'd0) ? 1 : int'(cfg_blocks);
   endfunction

   function automatic int list_pos(input logic [3:0] slot);
      for (int i = 0; i < pool_listed; i++)
         if (pool_order[i] == slot) return i;
      return pool_listed;
   endfunction

   // A free lands only in a listed chunk, below the chunk size, with room left.
   function automatic bit free_accepted(input logic [3:0] slot, input logic [7:0] blk);
      if (list_pos(slot) == pool_listed || !pool_used[slot]) return 1'b0;
      return (int'(blk) < blocks_now()) && (int'(pool_count[slot]) < blocks_now());
   endfunction

   function automatic int live_index(input logic [3:0] slot, input logic [7:0] blk);
      foreach (live_blocks[i])
         if (live_blocks[i].slot == slot && live_blocks[i].blk == blk) return i;
      return -1;
   endfunction

   function automatic void drop_last_chunk();
      pool_used[pool_order[pool_listed - 1]] = 1'b0;
      pool_listed--;
   endfunction

   function automatic grant_type grant_block();
      grant_type g;
      int pos;
      int s;
      logic [7:0] b;
      g = '0;
      pos = pool_alloc_pos;
      if (pos >= pool_listed || pool_count[pool_order[pos]] == 8'd0) begin
         pos = pool_listed;
         for (int i = 0; i < pool_listed; i++)
            if (pool_count[pool_order[i]] != 8'd0) begin
               pos = i;
               break;
            end
         if (pos == pool_listed) begin
            if (pool_listed >= MaxChunks) begin
               g.status = STATUS_NO_ROOM;
               return g;
            end
            s = 0;
            while (pool_used[s]) s++;
            // Open a fresh chunk: every link points at the next block.
            pool_used[s] = 1'b1;
            pool_head[s] = 8'd0;
            pool_count[s] = 8'(blocks_now());
            for (int i = 0; i < blocks_now(); i++) pool_link[s * 256 + i] = 8'(i + 1);
            pool_order[pool_listed] = 4'(s);
            pool_listed++;
         end
      end
      pool_alloc_pos = pos;
      s = pool_order[pos];
      b = pool_head[s];
      pool_head[s] = pool_link[s * 256 + b];
      pool_count[s]--;
      g.status = STATUS_OK;
      g.chunk = 4'(s);
      g.blk = b;
      g.offset = 16'(int'(b) * int'(cfg_block_size));
      return g;
   endfunction

   function automatic grant_type return_block(input logic [3:0] slot, input logic [7:0] blk);
      grant_type g;
      int pos;
      int n;
      logic [3:0] last;
      g = '0;
      if (!free_accepted(slot, blk)) begin
         g.status = STATUS_BAD_FREE;
         return g;
      end
      n = pool_listed;
      pos = list_pos(slot);
      pool_link[slot * 256 + blk] = pool_head[slot];
      pool_head[slot] = blk;
      pool_count[slot]++;
      g.status = STATUS_OK;
      if (int'(pool_count[slot]) != blocks_now()) return g;
      // Chunk just went empty: release on a second empty one, else move it last.
      last = pool_order[n - 1];
      if (pos == n - 1) begin
         if (n > 1 && int'(pool_count[pool_order[n - 2]]) == blocks_now()) begin
            drop_last_chunk();
            pool_alloc_pos = 0;
         end
      end else if (int'(pool_count[last]) == blocks_now()) begin
         drop_last_chunk();
         pool_alloc_pos = pos;
      end else begin
         pool_order[pos] = last;
         pool_order[n - 1] = slot;
         pool_alloc_pos = n - 1;
      end
      return g;
   endfunction

   // Drive one request word, then record the predicted grant once it is taken.
   task automatic send_request(input bit mode, input logic [3:0] slot,
                               input logic [7:0] blk, input bit typed,
                               input grant_type typed_grant);
      int gap;
      int idx;
      grant_type g;
      block_ref_type r;
      gap = $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.mode = mode;
      req_ch.chunk_slot = slot;
      req_ch.block_index = blk;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      if (mode == MODE_ALLOC) begin
         g = grant_block();
         if (g.status == STATUS_OK) begin
            r.slot = g.chunk;
            r.blk = g.blk;
            live_blocks = {live_blocks, r};
         end
      end else begin
         g = return_block(slot, blk);
         idx = live_index(slot, blk);
         if (g.status == STATUS_OK && idx >= 0) live_blocks.delete(idx);
      end
      pending_grants = {pending_grants, (typed ? typed_grant : g)};
   endtask

   task automatic write_reg(input logic index, input logic [8:0] data);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = index;
      csr_ch.data = data;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      if (index == REG_BLOCK_SIZE) cfg_block_size = data;
      else cfg_blocks = data[7:0];
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic settle();
      wait (pending_grants.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   // Return every live block so a new chunk size never reaches stale links.
   task automatic drain_live();
      block_ref_type r;
      while (live_blocks.size() > 0) begin
         r = live_blocks.pop_front();
         send_request(MODE_FREE, r.slot, r.blk, 1'b0, '0);
      end
      @(negedge clock);
      req_ch.valid = 1'b0;
      settle();
   endtask

   task automatic random_phase(input int count, input bit hold_mid);
      int pick;
      int idx;
      logic [3:0] slot;
      logic [7:0] blk;
      for (int k = 0; k < count; k++) begin
         if (hold_mid && k == count / 2) begin
            // Hold the sender until the pool is fully answered.
            @(negedge clock);
            req_ch.valid = 1'b0;
            wait (pending_grants.size() == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 55 || (pick < 90 && live_blocks.size() == 0)) begin
            send_request(MODE_ALLOC, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                         1'b0, '0);
         end else if (pick < 90) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            send_request(MODE_FREE, live_blocks[idx].slot, live_blocks[idx].blk, 1'b0, '0);
         end else begin
            // Noise: never free a block that is not handed out.
            slot = 4'($urandom_range(0, 15));
            blk = 8'($urandom_range(0, 255));
            if (free_accepted(slot, blk) && live_index(slot, blk) < 0) blk = 8'd255;
            send_request(MODE_FREE, slot, blk, 1'b0, '0);
         end
      end
   endtask

   // Response side: draw a stall per word, then compare with the oldest grant.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = 1'b0;
         repeat ($urandom_range(0, 9)) @(negedge clock);
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected response status %0d", $time, rsp_ch.status);
            fail_count++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status exp %0d got %0d", $time, want.status, rsp_ch.status);
               fail_count++;
            end
            if (rsp_ch.granted_chunk !== want.chunk) begin
               $display("%0t: granted_chunk exp %0d got %0d", $time, want.chunk,
                        rsp_ch.granted_chunk);
               fail_count++;
            end
            if (rsp_ch.granted_block !== want.blk) begin
               $display("%0t: granted_block exp %0d got %0d", $time, want.blk,
                        rsp_ch.granted_block);
               fail_count++;
            end
            if (rsp_ch.byte_offset !== want.offset) begin
               $display("%0t: byte_offset exp %0d got %0d", $time, want.offset,
                        rsp_ch.byte_offset);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_ALLOC;
      req_ch.chunk_slot = '0;
      req_ch.block_index = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_BLOCK_SIZE;
      csr_ch.data = '0;
      // Reset state of the pool model.
      pool_used = '0;
      pool_listed = 0;
      pool_alloc_pos = NO_POS;
      cfg_block_size = 9'd1;
      cfg_blocks = 8'd255;
      foreach (pool_link[i]) pool_link[i] = '0;
      foreach (pool_head[i]) begin
         pool_head[i] = '0;
         pool_count[i] = '0;
         pool_order[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words at the largest block size and full chunks.
      write_reg(REG_BLOCK_SIZE, 9'd256);
      foreach (directed_rows[i])
         send_request(directed_rows[i].mode, directed_rows[i].slot, directed_rows[i].blk,
                      directed_rows[i].typed, directed_rows[i].grant);

      // Chunk size only shrinks from phase to phase, after every block is back.
      drain_live();
      write_reg(REG_BLOCK_SIZE, 9'd1);
      write_reg(REG_BLOCKS_PER_CHUNK, 9'd255);
      random_phase(140, 1'b0);
      drain_live();
      write_reg(REG_BLOCK_SIZE, 9'd37);
      write_reg(REG_BLOCKS_PER_CHUNK, 9'd8);
      random_phase(110, 1'b1);
      drain_live();
      write_reg(REG_BLOCK_SIZE, 9'd256);
      write_reg(REG_BLOCKS_PER_CHUNK, 9'd2);
      random_phase(110, 1'b0);
      drain_live();
      write_reg(REG_BLOCK_SIZE, 9'd5);
      write_reg(REG_BLOCKS_PER_CHUNK, 9'd1);
      random_phase(140, 1'b0);

      @(negedge clock);
      req_ch.valid = 1'b0;
      wait (pending_grants.size() == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

[chunked_fixed_block_allocator_unit.f]
sv/cfba_pkg.sv
sv/cfba_if.sv
sv/cfba_link_ram.sv
sv/chunked_fixed_block_allocator_unit.sv
bench/chunked_fixed_block_allocator_unit_tb.sv
